// ===== rtl/bleg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bleg_pkg: shared definitions for the biped spring-leg dynamics unit
// Field widths, pipeline word types, register indexes and small helpers.
// ----------------------------------------------------------------------------
package bleg_pkg;

	localparam int DATA_W    = 32;
	localparam int FRAC_W    = 16;
	localparam int CFG_W     = 31;
	localparam int CFG_IDX_W = 3;
	localparam int OFF_W     = DATA_W + 1;
	localparam int SQ_W      = 2 * OFF_W;
	localparam int ROOT_W    = 35;
	localparam int RAD_W     = 2 * ROOT_W;
	localparam int REM_W     = ROOT_W + 1;
	localparam int FORCE_W   = 2 * CFG_W - FRAC_W;
	localparam int UNIT_W    = FRAC_W + 1;
	localparam int COMP_W    = UNIT_W + FORCE_W - FRAC_W;
	localparam int SUM_W     = COMP_W + 2;
	localparam int MAG_W     = COMP_W + 1;
	localparam int QUOT_W    = 34;
	localparam int HEAD_W    = QUOT_W - FRAC_W;
	localparam int ACC_W     = ROOT_W + 2;
	localparam int LANES     = 6;
	localparam int AXES      = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_K_ONE    = 3'd0,
		REG_K_TWO    = 3'd1,
		REG_REST_ONE = 3'd2,
		REG_REST_TWO = 3'd3,
		REG_MASS     = 3'd4,
		REG_GRAVITY  = 3'd5,
		REG_LEAD_ONE = 3'd6
	} cfg_reg_t;

	// Offset sign flags: lead x, lead z, trail x, trail z, vertical.
	typedef struct packed {
		logic [DATA_W-1:0] vx;
		logic [DATA_W-1:0] vy;
		logic [DATA_W-1:0] vz;
		logic [4:0]        neg;
		logic [OFF_W-1:0]  mlx;
		logic [OFF_W-1:0]  mlz;
		logic [OFF_W-1:0]  mtx;
		logic [OFF_W-1:0]  mtz;
		logic [OFF_W-1:0]  mpy;
	} geo_t;

	typedef struct packed {
		geo_t            g;
		logic [SQ_W-1:0] sqlx;
		logic [SQ_W-1:0] sqlz;
		logic [SQ_W-1:0] sqtx;
		logic [SQ_W-1:0] sqtz;
		logic [SQ_W-1:0] sqpy;
	} sq_t;

	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [ROOT_W-1:0] root;
		logic [REM_W-1:0]  rem;
	} isqrt_t;

	typedef struct packed {
		geo_t   g;
		isqrt_t l;
		isqrt_t t;
	} sqr_t;

	typedef struct packed {
		geo_t              g;
		logic [ROOT_W-1:0] len_l;
		logic [ROOT_W-1:0] len_t;
		logic [CFG_W-1:0]  diff_l;
		logic [CFG_W-1:0]  diff_t;
		logic [DATA_W-1:0] resid;
		logic              degen;
	} pst_t;

	typedef struct packed {
		logic [DATA_W-1:0] vx;
		logic [DATA_W-1:0] vy;
		logic [DATA_W-1:0] vz;
		logic [4:0]        neg;
		logic [DATA_W-1:0] resid;
		logic              degen;
	} side_t;

	typedef struct packed {
		side_t                         sd;
		logic [LANES-1:0]              lsb;
		logic [ROOT_W-1:0]             len_l;
		logic [ROOT_W-1:0]             len_t;
		logic [FORCE_W-1:0]            force_l;
		logic [FORCE_W-1:0]            force_t;
		logic [LANES-1:0][ROOT_W-1:0]  rem;
		logic [LANES-1:0][UNIT_W-1:0]  quot;
	} dvu_t;

	typedef struct packed {
		side_t                        sd;
		logic [LANES-1:0][COMP_W-1:0] comp;
	} cmp_t;

	typedef struct packed {
		side_t                      sd;
		logic [AXES-1:0][SUM_W-1:0] sum;
	} sum_t;

	typedef struct packed {
		side_t                       sd;
		logic [AXES-1:0]             sgn;
		logic [AXES-1:0]             ovf;
		logic [AXES-1:0][HEAD_W-1:0] low;
		logic [AXES-1:0][CFG_W-1:0]  rem;
		logic [AXES-1:0][QUOT_W-1:0] quot;
	} acc_t;

	function automatic logic [OFF_W-1:0] abs_off(logic signed [OFF_W-1:0] v);
		logic [OFF_W-1:0] r;
		r = v[OFF_W-1] ? OFF_W'(-v) : OFF_W'(v);
		return r;
	endfunction

	// One restoring square-root step: two radicand bits in, one root bit out.
	function automatic isqrt_t isqrt_step(isqrt_t a);
		isqrt_t             r;
		logic [REM_W+1:0]   acc;
		logic [REM_W+1:0]   trial;
		acc     = {a.rem, a.rad[RAD_W-1 -: 2]};
		trial   = (REM_W+2)'({a.root, 2'b01});
		r.rad   = a.rad << 2;
		if (acc >= trial) begin
			r.rem  = REM_W'(acc - trial);
			r.root = {a.root[ROOT_W-2:0], 1'b1};
		end else begin
			r.rem  = REM_W'(acc);
			r.root = {a.root[ROOT_W-2:0], 1'b0};
		end
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] sat_data(logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
		lo = ~hi;
		if (v > hi)
			return hi[DATA_W-1:0];
		else if (v < lo)
			return lo[DATA_W-1:0];
		else
			return v[DATA_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/bleg_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bleg_in_if: request channel of the spring-leg dynamics unit
// Center-of-mass state and the two foot points, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bleg_in_if;
	import bleg_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] pos_x;
	logic signed [DATA_W-1:0] pos_y;
	logic signed [DATA_W-1:0] pos_z;
	logic signed [DATA_W-1:0] vel_x;
	logic signed [DATA_W-1:0] vel_y;
	logic signed [DATA_W-1:0] vel_z;
	logic signed [DATA_W-1:0] lead_foot_x;
	logic signed [DATA_W-1:0] lead_foot_z;
	logic signed [DATA_W-1:0] trail_foot_x;
	logic signed [DATA_W-1:0] trail_foot_z;

	modport source (
		output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
		       lead_foot_x, lead_foot_z, trail_foot_x, trail_foot_z,
		input  ready
	);
	modport sink (
		input  valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
		       lead_foot_x, lead_foot_z, trail_foot_x, trail_foot_z,
		output ready
	);
endinterface
`default_nettype wire

// ===== rtl/bleg_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bleg_out_if: result channel of the spring-leg dynamics unit
// State derivative, takeoff residual and degenerate flag, valid/ready.
// ----------------------------------------------------------------------------
interface bleg_out_if;
	import bleg_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] rate_x;
	logic signed [DATA_W-1:0] rate_y;
	logic signed [DATA_W-1:0] rate_z;
	logic signed [DATA_W-1:0] accel_x;
	logic signed [DATA_W-1:0] accel_y;
	logic signed [DATA_W-1:0] accel_z;
	logic signed [DATA_W-1:0] takeoff_residual;
	logic                     degenerate;

	modport source (
		output valid, rate_x, rate_y, rate_z, accel_x, accel_y, accel_z,
		       takeoff_residual, degenerate,
		input  ready
	);
	modport sink (
		input  valid, rate_x, rate_y, rate_z, accel_x, accel_y, accel_z,
		       takeoff_residual, degenerate,
		output ready
	);
endinterface
`default_nettype wire

// ===== rtl/biped_spring_leg_dynamics_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// biped_spring_leg_dynamics_unit: double-support spring-mass walker dynamics
// Fully pipelined Q16.16 state-derivative evaluator with a write-only
// register port for leg stiffness, rest length, mass, gravity and leg order.
// ----------------------------------------------------------------------------
// The unit takes one request per cycle while the output is not stalled and
// returns one result per request, in order. The pipeline holds 35
// square-root stages for the leg lengths, 17 stages for the direction
// cosines and 34 stages for the division by body mass, plus the geometry,
// square, compression, force, projection, sum and output stages. The whole
// pipeline advances together; it holds while the output register is full
// and not taken, so ready follows the output side. Registers may be written
// only while no request is in flight.
module biped_spring_leg_dynamics_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [bleg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bleg_pkg::DATA_W-1:0]    cfg_data,
	bleg_in_if.sink                        in_ch,
	bleg_out_if.source                     out_ch
);
	import bleg_pkg::*;

	logic [CFG_W-1:0]         k1_q, k2_q, r1_q, r2_q, mass_q;
	logic signed [DATA_W-1:0] grav_q;
	logic                     lead_one_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k1_q       <= '0;
			k2_q       <= '0;
			r1_q       <= CFG_W'(1 << FRAC_W);
			r2_q       <= CFG_W'(1 << FRAC_W);
			mass_q     <= CFG_W'(1 << FRAC_W);
			grav_q     <= '0;
			lead_one_q <= 1'b1;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_K_ONE:    k1_q       <= cfg_data[CFG_W-1:0];
				REG_K_TWO:    k2_q       <= cfg_data[CFG_W-1:0];
				REG_REST_ONE: r1_q       <= cfg_data[CFG_W-1:0];
				REG_REST_TWO: r2_q       <= cfg_data[CFG_W-1:0];
				REG_MASS:     mass_q     <= cfg_data[CFG_W-1:0];
				REG_GRAVITY:  grav_q     <= cfg_data;
				REG_LEAD_ONE: lead_one_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic [CFG_W-1:0] k_lead, k_trail, rest_lead, rest_trail, m_eff;
	assign k_lead     = lead_one_q ? k1_q : k2_q;
	assign k_trail    = lead_one_q ? k2_q : k1_q;
	assign rest_lead  = lead_one_q ? r1_q : r2_q;
	assign rest_trail = lead_one_q ? r2_q : r1_q;
	assign m_eff      = (mass_q == '0) ? CFG_W'(1) : mass_q;

	logic out_valid_q;
	logic adv;
	assign adv         = !out_valid_q || out_ch.ready;
	assign in_ch.ready = adv;

	// Geometry: offsets from each foot and their magnitudes.
	logic signed [OFF_W-1:0] d_lx, d_lz, d_tx, d_tz, d_py;
	geo_t geo_in;
	assign d_lx = OFF_W'(in_ch.pos_x) - OFF_W'(in_ch.lead_foot_x);
	assign d_lz = OFF_W'(in_ch.pos_z) - OFF_W'(in_ch.lead_foot_z);
	assign d_tx = OFF_W'(in_ch.pos_x) - OFF_W'(in_ch.trail_foot_x);
	assign d_tz = OFF_W'(in_ch.pos_z) - OFF_W'(in_ch.trail_foot_z);
	assign d_py = OFF_W'(in_ch.pos_y);

	always_comb begin
		geo_in.vx  = in_ch.vel_x;
		geo_in.vy  = in_ch.vel_y;
		geo_in.vz  = in_ch.vel_z;
		geo_in.neg = {d_py[OFF_W-1], d_tz[OFF_W-1], d_tx[OFF_W-1],
		              d_lz[OFF_W-1], d_lx[OFF_W-1]};
		geo_in.mlx = abs_off(d_lx);
		geo_in.mlz = abs_off(d_lz);
		geo_in.mtx = abs_off(d_tx);
		geo_in.mtz = abs_off(d_tz);
		geo_in.mpy = abs_off(d_py);
	end

	geo_t geo_s1;
	logic geo_v_s1;
	sq_t  sq_s2;
	logic sq_v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geo_v_s1 <= 1'b0;
			sq_v_s2  <= 1'b0;
		end else if (adv) begin
			geo_v_s1 <= in_ch.valid;
			sq_v_s2  <= geo_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			geo_s1     <= geo_in;
			sq_s2.g    <= geo_s1;
			sq_s2.sqlx <= SQ_W'(geo_s1.mlx) * SQ_W'(geo_s1.mlx);
			sq_s2.sqlz <= SQ_W'(geo_s1.mlz) * SQ_W'(geo_s1.mlz);
			sq_s2.sqtx <= SQ_W'(geo_s1.mtx) * SQ_W'(geo_s1.mtx);
			sq_s2.sqtz <= SQ_W'(geo_s1.mtz) * SQ_W'(geo_s1.mtz);
			sq_s2.sqpy <= SQ_W'(geo_s1.mpy) * SQ_W'(geo_s1.mpy);
		end
	end

	// Leg lengths: one root bit per stage for both legs.
	sqr_t sqr_s   [0:ROOT_W];
	logic sqr_v_s [0:ROOT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sqr_v_s[0] <= 1'b0;
		else if (adv)
			sqr_v_s[0] <= sq_v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sqr_s[0].g      <= sq_s2.g;
			sqr_s[0].l.rad  <= RAD_W'(sq_s2.sqlx + sq_s2.sqpy + sq_s2.sqlz);
			sqr_s[0].l.root <= '0;
			sqr_s[0].l.rem  <= '0;
			sqr_s[0].t.rad  <= RAD_W'(sq_s2.sqtx + sq_s2.sqpy + sq_s2.sqtz);
			sqr_s[0].t.root <= '0;
			sqr_s[0].t.rem  <= '0;
		end
	end

	for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sqr_v_s[i+1] <= 1'b0;
			else if (adv)
				sqr_v_s[i+1] <= sqr_v_s[i];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sqr_s[i+1].g <= sqr_s[i].g;
				sqr_s[i+1].l <= isqrt_step(sqr_s[i].l);
				sqr_s[i+1].t <= isqrt_step(sqr_s[i].t);
			end
		end
	end

	// Compression and takeoff residual.
	pst_t                    pst_in, pst_s;
	logic                    pst_v_s;
	logic signed [ACC_W-1:0] rdiff;

	always_comb begin
		pst_in.g     = sqr_s[ROOT_W].g;
		pst_in.len_l = sqr_s[ROOT_W].l.root;
		pst_in.len_t = sqr_s[ROOT_W].t.root;
		pst_in.degen = (pst_in.len_l == '0) || (pst_in.len_t == '0);
		if (pst_in.len_l != '0 && pst_in.len_l < ROOT_W'(rest_lead))
			pst_in.diff_l = CFG_W'(ROOT_W'(rest_lead) - pst_in.len_l);
		else
			pst_in.diff_l = '0;
		if (pst_in.len_t != '0 && pst_in.len_t < ROOT_W'(rest_trail))
			pst_in.diff_t = CFG_W'(ROOT_W'(rest_trail) - pst_in.len_t);
		else
			pst_in.diff_t = '0;
		rdiff        = $signed(ACC_W'(pst_in.len_t)) - $signed(ACC_W'(rest_trail));
		pst_in.resid = sat_data(rdiff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pst_v_s <= 1'b0;
		else if (adv)
			pst_v_s <= sqr_v_s[ROOT_W];
	end

	always_ff @(posedge clk) begin
		if (adv)
			pst_s <= pst_in;
	end

	// Spring force and setup of the six direction-cosine dividers.
	logic [2*CFG_W-1:0]            prod_l, prod_t;
	logic [LANES-1:0][OFF_W-1:0]   mg;
	dvu_t                          dvu_in;

	always_comb begin
		prod_l = (2*CFG_W)'(k_lead) * (2*CFG_W)'(pst_s.diff_l);
		prod_t = (2*CFG_W)'(k_trail) * (2*CFG_W)'(pst_s.diff_t);
		mg[0]  = pst_s.g.mlx;
		mg[1]  = pst_s.g.mpy;
		mg[2]  = pst_s.g.mlz;
		mg[3]  = pst_s.g.mtx;
		mg[4]  = pst_s.g.mpy;
		mg[5]  = pst_s.g.mtz;
		dvu_in.sd.vx    = pst_s.g.vx;
		dvu_in.sd.vy    = pst_s.g.vy;
		dvu_in.sd.vz    = pst_s.g.vz;
		dvu_in.sd.neg   = pst_s.g.neg;
		dvu_in.sd.resid = pst_s.resid;
		dvu_in.sd.degen = pst_s.degen;
		dvu_in.len_l    = pst_s.len_l;
		dvu_in.len_t    = pst_s.len_t;
		dvu_in.force_l  = prod_l[2*CFG_W-1:FRAC_W];
		dvu_in.force_t  = prod_t[2*CFG_W-1:FRAC_W];
		for (int k = 0; k < LANES; k++) begin
			dvu_in.lsb[k]  = mg[k][0];
			dvu_in.rem[k]  = ROOT_W'(mg[k] >> 1);
			dvu_in.quot[k] = '0;
		end
	end

	dvu_t dvu_s   [0:UNIT_W];
	logic dvu_v_s [0:UNIT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dvu_v_s[0] <= 1'b0;
		else if (adv)
			dvu_v_s[0] <= pst_v_s;
	end

	always_ff @(posedge clk) begin
		if (adv)
			dvu_s[0] <= dvu_in;
	end

	for (genvar j = 0; j < UNIT_W; j++) begin : g_unit
		dvu_t nxt;
		always_comb begin
			logic [ROOT_W:0]   acc;
			logic [ROOT_W-1:0] dvsr;
			logic              ge;
			nxt = dvu_s[j];
			for (int k = 0; k < LANES; k++) begin
				dvsr = (k < LANES/2) ? dvu_s[j].len_l : dvu_s[j].len_t;
				acc  = {dvu_s[j].rem[k], (j == 0) ? dvu_s[j].lsb[k] : 1'b0};
				ge   = acc >= (ROOT_W+1)'(dvsr);
				nxt.rem[k]  = ge ? ROOT_W'(acc - (ROOT_W+1)'(dvsr)) : ROOT_W'(acc);
				nxt.quot[k] = {dvu_s[j].quot[k][UNIT_W-2:0], ge};
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dvu_v_s[j+1] <= 1'b0;
			else if (adv)
				dvu_v_s[j+1] <= dvu_v_s[j];
		end
		always_ff @(posedge clk) begin
			if (adv)
				dvu_s[j+1] <= nxt;
		end
	end

	// Projection of each leg force on the three axes.
	cmp_t cmp_in, cmp_s;
	logic cmp_v_s;

	always_comb begin
		logic [UNIT_W+FORCE_W-1:0] prod;
		logic [FORCE_W-1:0]        frc;
		cmp_in.sd = dvu_s[UNIT_W].sd;
		for (int k = 0; k < LANES; k++) begin
			frc  = (k < LANES/2) ? dvu_s[UNIT_W].force_l : dvu_s[UNIT_W].force_t;
			prod = (UNIT_W+FORCE_W)'(dvu_s[UNIT_W].quot[k]) * (UNIT_W+FORCE_W)'(frc);
			cmp_in.comp[k] = prod[UNIT_W+FORCE_W-1:FRAC_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cmp_v_s <= 1'b0;
		else if (adv)
			cmp_v_s <= dvu_v_s[UNIT_W];
	end

	always_ff @(posedge clk) begin
		if (adv)
			cmp_s <= cmp_in;
	end

	// Signed sum of both legs per axis.
	sum_t                           sum_in, sum_s;
	logic                           sum_v_s;
	logic [LANES-1:0]               lane_neg;
	logic signed [LANES-1:0][SUM_W-1:0] term;

	always_comb begin
		lane_neg = {cmp_s.sd.neg[3], cmp_s.sd.neg[4], cmp_s.sd.neg[2],
		            cmp_s.sd.neg[1], cmp_s.sd.neg[4], cmp_s.sd.neg[0]};
		for (int k = 0; k < LANES; k++)
			term[k] = lane_neg[k] ? -SUM_W'(cmp_s.comp[k]) : SUM_W'(cmp_s.comp[k]);
		sum_in.sd = cmp_s.sd;
		for (int a = 0; a < AXES; a++)
			sum_in.sum[a] = term[a] + term[a+AXES];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sum_v_s <= 1'b0;
		else if (adv)
			sum_v_s <= cmp_v_s;
	end

	always_ff @(posedge clk) begin
		if (adv)
			sum_s <= sum_in;
	end

	// Magnitude and overflow check ahead of the division by mass. A quotient
	// of 2^34 or more saturates whatever gravity adds.
	acc_t acc_in;

	always_comb begin
		logic [SUM_W-1:0] neg_sum;
		logic [MAG_W-1:0] mgs;
		acc_in.sd = sum_s.sd;
		for (int a = 0; a < AXES; a++) begin
			neg_sum         = -sum_s.sum[a];
			acc_in.sgn[a]   = sum_s.sum[a][SUM_W-1];
			mgs             = acc_in.sgn[a] ? neg_sum[MAG_W-1:0] : sum_s.sum[a][MAG_W-1:0];
			acc_in.ovf[a]   = (MAG_W+1)'(mgs) >= (MAG_W+1)'({m_eff, {HEAD_W{1'b0}}});
			acc_in.rem[a]   = CFG_W'(mgs >> HEAD_W);
			acc_in.low[a]   = mgs[HEAD_W-1:0];
			acc_in.quot[a]  = '0;
		end
	end

	acc_t acc_s   [0:QUOT_W];
	logic acc_v_s [0:QUOT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			acc_v_s[0] <= 1'b0;
		else if (adv)
			acc_v_s[0] <= sum_v_s;
	end

	always_ff @(posedge clk) begin
		if (adv)
			acc_s[0] <= acc_in;
	end

	for (genvar j = 0; j < QUOT_W; j++) begin : g_mass
		acc_t nxt;
		always_comb begin
			logic [CFG_W:0] acc;
			logic           ge;
			nxt = acc_s[j];
			for (int a = 0; a < AXES; a++) begin
				acc = {acc_s[j].rem[a], acc_s[j].low[a][HEAD_W-1]};
				ge  = acc >= (CFG_W+1)'(m_eff);
				nxt.rem[a]  = ge ? CFG_W'(acc - (CFG_W+1)'(m_eff)) : CFG_W'(acc);
				nxt.low[a]  = acc_s[j].low[a] << 1;
				nxt.quot[a] = {acc_s[j].quot[a][QUOT_W-2:0], ge};
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				acc_v_s[j+1] <= 1'b0;
			else if (adv)
				acc_v_s[j+1] <= acc_v_s[j];
		end
		always_ff @(posedge clk) begin
			if (adv)
				acc_s[j+1] <= nxt;
		end
	end

	// Sign, gravity and saturation into the output register.
	logic [AXES-1:0][DATA_W-1:0] accel;

	always_comb begin
		logic signed [ACC_W-1:0] qv;
		logic signed [ACC_W-1:0] v;
		for (int a = 0; a < AXES; a++) begin
			qv = ACC_W'(acc_s[QUOT_W].quot[a]);
			v  = acc_s[QUOT_W].sgn[a] ? -qv : qv;
			if (a == 1)
				v = v + ACC_W'(grav_q);
			if (acc_s[QUOT_W].ovf[a])
				accel[a] = acc_s[QUOT_W].sgn[a] ? {1'b1, {(DATA_W-1){1'b0}}}
				                               : {1'b0, {(DATA_W-1){1'b1}}};
			else
				accel[a] = sat_data(v);
		end
	end

	logic [DATA_W-1:0] rate_x_q, rate_y_q, rate_z_q;
	logic [DATA_W-1:0] accel_x_q, accel_y_q, accel_z_q, resid_q;
	logic              degen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= acc_v_s[QUOT_W];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rate_x_q  <= acc_s[QUOT_W].sd.vx;
			rate_y_q  <= acc_s[QUOT_W].sd.vy;
			rate_z_q  <= acc_s[QUOT_W].sd.vz;
			accel_x_q <= accel[0];
			accel_y_q <= accel[1];
			accel_z_q <= accel[2];
			resid_q   <= acc_s[QUOT_W].sd.resid;
			degen_q   <= acc_s[QUOT_W].sd.degen;
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.rate_x           = rate_x_q;
	assign out_ch.rate_y           = rate_y_q;
	assign out_ch.rate_z           = rate_z_q;
	assign out_ch.accel_x          = accel_x_q;
	assign out_ch.accel_y          = accel_y_q;
	assign out_ch.accel_z          = accel_z_q;
	assign out_ch.takeoff_residual = resid_q;
	assign out_ch.degenerate       = degen_q;

endmodule
`default_nettype wire
